### sv/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and constants of the quicksort engine: beat payloads, the
// range stack control group and the default store depth.
// ----------------------------------------------------------------------------
package qse_pkg;

    localparam int VALUE_W   = 32;
    localparam int QSE_DEPTH = 64;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_run;
        logic                      overflowed;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

endpackage

### sv/qse_ram.sv
// ----------------------------------------------------------------------------
// qse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/qse_key_cmp.sv
// ----------------------------------------------------------------------------
// qse_key_cmp
// Shared compare unit: tells whether a stored value sits at or below the pivot
// in signed order.
// ----------------------------------------------------------------------------
module qse_key_cmp
    import qse_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    input  logic [VALUE_W-1:0] pivot,
    output logic               le
);

    logic [VALUE_W-1:0] value_key;
    logic [VALUE_W-1:0] pivot_key;

    // flip the sign bit so that unsigned order follows signed order
    assign value_key = value ^ {1'b1, {(VALUE_W-1){1'b0}}};
    assign pivot_key = pivot ^ {1'b1, {(VALUE_W-1){1'b0}}};
    assign le        = (value_key <= pivot_key);

endmodule

### sv/qse_range_stack.sv
// ----------------------------------------------------------------------------
// qse_range_stack
// Stack of pending subranges (low and high index) for the partition loop.
// ----------------------------------------------------------------------------
module qse_range_stack
    import qse_pkg::*;
#(
    parameter int DEPTH = QSE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  stk_ctrl_t                ctrl,
    input  logic [$clog2(DEPTH)-1:0] push_lo,
    input  logic [$clog2(DEPTH)-1:0] push_hi,
    output logic [$clog2(DEPTH)-1:0] top_lo,
    output logic [$clog2(DEPTH)-1:0] top_hi,
    output logic                     empty
);

    localparam int AW        = $clog2(DEPTH);
    // smaller side first keeps at most log2(DEPTH) ranges pending
    localparam int STK_DEPTH = AW + 1;
    localparam int IW        = $clog2(STK_DEPTH);
    localparam int SPW       = $clog2(STK_DEPTH + 1);

    logic [AW-1:0]  lo_mem [STK_DEPTH];
    logic [AW-1:0]  hi_mem [STK_DEPTH];
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_next;
    logic [SPW-1:0] sp_dec;
    logic           full;

    assign sp_dec = sp_reg - SPW'(1);
    assign full   = (sp_reg == SPW'(STK_DEPTH));
    assign empty  = (sp_reg == '0);
    assign top_lo = lo_mem[sp_dec[IW-1:0]];
    assign top_hi = hi_mem[sp_dec[IW-1:0]];

    always_comb
    begin
        sp_next = sp_reg;
        if (ctrl.push && !full)
        begin
            sp_next = sp_reg + SPW'(1);
        end
        else if (ctrl.pop && !empty)
        begin
            sp_next = sp_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !full)
        begin
            lo_mem[sp_reg[IW-1:0]] <= push_lo;
            hi_mem[sp_reg[IW-1:0]] <= push_hi;
        end
    end

endmodule

### sv/quicksort_engine_top.sv
// ----------------------------------------------------------------------------
// quicksort_engine_top
// Collects signed values into a store, sorts them in place by quicksort and
// streams them back in ascending order.
// ----------------------------------------------------------------------------
// Values arrive one per beat and are written to a DEPTH-entry RAM, one beat
// per cycle while loading; values beyond DEPTH are dropped and every result
// of that set then carries overflowed. The beat with is_last starts the sort,
// during which item_stall stays high. Each partition takes its first element
// as pivot: the pivot is read, then each forward or backward scan step is one
// RAM read compared by the shared compare unit against the pivot, each swap
// writes both values back and the pivot is placed in its final slot before
// the range bookkeeping. Emitting is slowed only by result_stall.
// Subranges still to be sorted sit on a small stack; the smaller side is
// always worked first so it never holds more than log2(DEPTH) ranges.
// ----------------------------------------------------------------------------
module quicksort_engine_top
    import qse_pkg::*;
#(
    parameter int DEPTH = QSE_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_PIV    = 4'd1;
    localparam logic [3:0] S_PIVCAP = 4'd2;
    localparam logic [3:0] S_ISCAN  = 4'd3;
    localparam logic [3:0] S_JSCAN  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_SW1    = 4'd6;
    localparam logic [3:0] S_SW2    = 4'd7;
    localparam logic [3:0] S_FIN1   = 4'd8;
    localparam logic [3:0] S_FIN2   = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_ERD    = 4'd11;
    localparam logic [3:0] S_EOUT   = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               drop_reg, drop_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [AW-1:0]      j_reg, j_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [VALUE_W-1:0] pivot_reg, pivot_next;
    logic [VALUE_W-1:0] vi_reg, vi_next;
    logic [VALUE_W-1:0] vj_reg, vj_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    // ram port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // range stack
    stk_ctrl_t          stk_ctrl;
    logic [AW-1:0]      stk_push_lo;
    logic [AW-1:0]      stk_push_hi;
    logic [AW-1:0]      stk_top_lo;
    logic [AW-1:0]      stk_top_hi;
    logic               stk_empty;

    // helpers
    logic               le;
    logic               item_take;
    logic               has_room;
    logic               slot_free;
    logic [AW-1:0]      i_inc;
    logic [AW-1:0]      j_inc;
    logic [AW-1:0]      j_dec;
    logic [AW-1:0]      k_inc;
    logic [CW-1:0]      k_count;
    logic [AW-1:0]      left_len;
    logic [AW-1:0]      right_len;
    logic               left_ok;
    logic               right_ok;

    qse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qse_key_cmp u_cmp (
        .value (ram_rdata),
        .pivot (pivot_reg),
        .le    (le)
    );

    qse_range_stack #(
        .DEPTH (DEPTH)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (stk_ctrl),
        .push_lo (stk_push_lo),
        .push_hi (stk_push_hi),
        .top_lo  (stk_top_lo),
        .top_hi  (stk_top_hi),
        .empty   (stk_empty)
    );

    assign item_stall   = (state_reg != S_LOAD);
    assign item_take    = item_valid && !item_stall;
    assign has_room     = (count_reg < CW'(DEPTH));
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    // output register can take a new beat this cycle
    assign slot_free    = !out_valid_reg || !result_stall;

    assign i_inc     = i_reg + AW'(1);
    assign j_inc     = j_reg + AW'(1);
    assign j_dec     = j_reg - AW'(1);
    assign k_inc     = k_reg + AW'(1);
    assign k_count   = CW'(k_reg) + CW'(1);
    assign left_len  = j_reg - lo_reg;
    assign right_len = hi_reg - j_reg;
    assign left_ok   = (left_len > AW'(1));
    assign right_ok  = (right_len > AW'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pivot_next     = pivot_reg;
        vi_next        = vi_reg;
        vj_next        = vj_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = item.value;
        ram_raddr      = lo_reg;
        stk_ctrl       = '0;
        stk_push_lo    = lo_reg;
        stk_push_hi    = hi_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (item_take)
                begin
                    if (has_room)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (item.is_last)
                    begin
                        lo_next = '0;
                        k_next  = '0;
                        hi_next = has_room ? count_reg[AW-1:0] : AW'(DEPTH - 1);
                        // a single value needs no sorting
                        state_next = (count_reg == '0) ? S_ERD : S_PIV;
                    end
                end
            end

            S_PIV:
            begin
                ram_raddr  = lo_reg;
                state_next = S_PIVCAP;
            end

            S_PIVCAP:
            begin
                pivot_next = ram_rdata;
                i_next     = lo_reg;
                j_next     = hi_reg;
                ram_raddr  = lo_reg;
                state_next = S_ISCAN;
            end

            // forward scan: pass values not above the pivot
            S_ISCAN:
            begin
                if (le && (i_inc != hi_reg))
                begin
                    i_next    = i_inc;
                    ram_raddr = i_inc;
                end
                else
                begin
                    if (le)
                    begin
                        i_next = hi_reg;
                    end
                    else
                    begin
                        vi_next = ram_rdata;
                    end
                    ram_raddr  = j_reg;
                    state_next = S_JSCAN;
                end
            end

            // backward scan: pass values above the pivot
            S_JSCAN:
            begin
                ram_raddr = j_dec;
                if (!le && (j_dec != lo_reg))
                begin
                    j_next = j_dec;
                end
                else
                begin
                    if (!le)
                    begin
                        j_next = lo_reg;
                    end
                    else
                    begin
                        vj_next = ram_rdata;
                    end
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = (i_reg < j_reg) ? S_SW1 : S_FIN1;
            end

            S_SW1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = vj_reg;
                state_next = S_SW2;
            end

            S_SW2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = vi_reg;
                ram_raddr  = i_reg;
                state_next = S_ISCAN;
            end

            // pivot into its final slot
            S_FIN1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = pivot_reg;
                state_next = S_FIN2;
            end

            S_FIN2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = (j_reg == lo_reg) ? pivot_reg : vj_reg;
                state_next = S_NEXT;
            end

            // next range: smaller side now, larger stacked; else pop or emit
            S_NEXT:
            begin
                state_next = S_PIV;
                priority if (left_ok && right_ok)
                begin
                    stk_ctrl.push = 1'b1;
                    if (left_len < right_len)
                    begin
                        stk_push_lo = j_inc;
                        stk_push_hi = hi_reg;
                        hi_next     = j_dec;
                    end
                    else
                    begin
                        stk_push_lo = lo_reg;
                        stk_push_hi = j_dec;
                        lo_next     = j_inc;
                    end
                end
                else if (left_ok)
                begin
                    hi_next = j_dec;
                end
                else if (right_ok)
                begin
                    lo_next = j_inc;
                end
                else if (!stk_empty)
                begin
                    stk_ctrl.pop = 1'b1;
                    lo_next      = stk_top_lo;
                    hi_next      = stk_top_hi;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
            end

            S_ERD:
            begin
                ram_raddr  = k_reg;
                state_next = S_EOUT;
            end

            // stream the store out; read data holds while the output is full
            S_EOUT:
            begin
                ram_raddr = k_reg;
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.sorted_value = ram_rdata;
                    out_next.end_of_run   = (k_count == count_reg);
                    out_next.overflowed   = drop_reg;
                    ram_raddr             = k_inc;
                    if (k_count == count_reg)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next = k_inc;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        vi_reg    <= vi_next;
        vj_reg    <= vj_next;
        out_reg   <= out_next;
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort engine testbench
// Streams sets of signed values into the engine and checks every sorted beat
// that comes back against an in-house quicksort of the same set. A short
// stimulus table covers the extremes, duplicates, ordered input and
// single-value sets. Full and overflowing sets follow. Random sets of mixed
// length and value style come after those. Both channels idle at random, and
// the result side once holds off long enough to back the engine up.
// ----------------------------------------------------------------------------
module testbench;
    import qse_pkg::*;

    localparam int      STORE_DEPTH = QSE_DEPTH;
    localparam int      STACK_SLOTS = 16;
    localparam int      ITEM_TARGET = 420;
    localparam int      MID_PAUSE_AT = 250;
    localparam int      LONG_HOLD = 400;
    localparam int      HOLD_TRIGGER = 60;
    localparam int      SETTLE_CYCLES = 40;
    localparam longint  TIMEOUT_NS = 64'd5_000_000;

    typedef logic signed [VALUE_W-1:0] sval_t;

    localparam sval_t MOST_NEG  = 32'sh8000_0000;
    localparam sval_t MOST_POS  = 32'sh7fff_ffff;
    localparam sval_t ZERO_V    = 32'sh0000_0000;
    localparam sval_t MINUS_ONE = 32'shffff_ffff;

    typedef enum int
    {
        FILL_SPREAD,
        FILL_FEW,
        FILL_EDGES,
        FILL_RISING,
        FILL_FALLING
    } fill_style_t;

    typedef enum int
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_SOLID
    } stall_mode_t;

    // one row of the stimulus table; the wanted result only counts when typed
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
        logic                      typed;
        logic signed [VALUE_W-1:0] want_value;
        logic                      want_end;
        logic                      want_ovf;
    } plan_row_t;

    // what the sender knows about a beat it has offered
    typedef struct {
        bit      typed;
        result_t want;
    } beat_note_t;

    localparam int PLAN_ROWS = 21;

    // value, last, typed, wanted value, wanted end, wanted overflow
    plan_row_t plan_rows [PLAN_ROWS] = '{
        // single-value sets at the extremes
        {MOST_NEG,     1'b1, 1'b1, MOST_NEG,  1'b1, 1'b0},
        {MOST_POS,     1'b1, 1'b1, MOST_POS,  1'b1, 1'b0},
        {ZERO_V,       1'b1, 1'b1, ZERO_V,    1'b1, 1'b0},
        {MINUS_ONE,    1'b1, 1'b1, MINUS_ONE, 1'b1, 1'b0},
        // mixed extremes and alternating bit patterns
        {MOST_POS,     1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {MOST_NEG,     1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {ZERO_V,       1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {MINUS_ONE,    1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {32'sd1,       1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {32'sh5555_5555, 1'b0, 1'b0, ZERO_V,  1'b0, 1'b0},
        {32'shaaaa_aaaa, 1'b1, 1'b0, ZERO_V,  1'b0, 1'b0},
        // all equal
        {32'sd5,       1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {32'sd5,       1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {32'sd5,       1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {32'sd5,       1'b1, 1'b0, ZERO_V,    1'b0, 1'b0},
        // already ascending
        {-32'sd3,      1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {-32'sd2,      1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {32'sd0,       1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {32'sd2,       1'b1, 1'b0, ZERO_V,    1'b0, 1'b0},
        // descending pair
        {32'sd9,       1'b0, 1'b0, ZERO_V,    1'b0, 1'b0},
        {-32'sd9,      1'b1, 1'b0, ZERO_V,    1'b0, 1'b0}
    };

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // predictor state: the set being collected and the results still owed
    sval_t      held_values [STORE_DEPTH];
    int         held_count = 0;
    bit         set_dropped = 1'b0;
    result_t    sorted_due [$];
    beat_note_t offered_notes [$];

    int beats_sent = 0;
    int results_seen = 0;
    int fail_count = 0;
    int burst_left = 0;

    quicksort_engine_top #(
        .DEPTH(STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // first element is the pivot; returns its final slot
    function automatic int partition_span(input int first, input int last);
        int    i;
        int    j;
        sval_t pivot;
        sval_t t;
        i = first;
        j = last;
        pivot = held_values[first];
        while (i < j)
        begin
            while (i < last && held_values[i] <= pivot)
                i++;
            while (j > first && held_values[j] > pivot)
                j--;
            if (i < j)
            begin
                t = held_values[i];
                held_values[i] = held_values[j];
                held_values[j] = t;
            end
        end
        t = held_values[first];
        held_values[first] = held_values[j];
        held_values[j] = t;
        return j;
    endfunction

    // smaller side worked first, larger side parked on the range stack
    function automatic void sort_held_values();
        int lo;
        int hi;
        int p;
        int depth;
        bit done;
        int pend_lo [STACK_SLOTS];
        int pend_hi [STACK_SLOTS];
        lo = 0;
        hi = held_count - 1;
        depth = 0;
        done = 1'b0;
        while (!done)
        begin
            while (lo < hi)
            begin
                p = partition_span(lo, hi);
                if (p - lo < hi - p)
                begin
                    if (hi > p + 1 && depth < STACK_SLOTS)
                    begin
                        pend_lo[depth] = p + 1;
                        pend_hi[depth] = hi;
                        depth++;
                    end
                    hi = p - 1;
                end
                else
                begin
                    if (p - 1 > lo && depth < STACK_SLOTS)
                    begin
                        pend_lo[depth] = lo;
                        pend_hi[depth] = p - 1;
                        depth++;
                    end
                    lo = p + 1;
                end
            end
            if (depth == 0)
                done = 1'b1;
            else
            begin
                depth--;
                lo = pend_lo[depth];
                hi = pend_hi[depth];
            end
        end
    endfunction

    // store one accepted value; the last one of a set releases the sorted set
    function automatic void absorb_value(input item_t b, input beat_note_t note);
        result_t r;
        int      k;
        if (held_count < STORE_DEPTH)
        begin
            held_values[held_count] = b.value;
            held_count++;
        end
        else
            set_dropped = 1'b1;
        if (b.is_last)
        begin
            sort_held_values();
            if (note.typed)
                sorted_due.push_back(note.want);
            else
            begin
                for (k = 0; k < held_count; k++)
                begin
                    r.sorted_value = held_values[k];
                    r.end_of_run = (k == held_count - 1);
                    r.overflowed = set_dropped;
                    sorted_due.push_back(r);
                end
            end
            held_count = 0;
            set_dropped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: accepted input beats feed the predictor, result beats are
    // checked against the oldest owed result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        beat_note_t note;
        result_t    want;
        if (rst_n && item_valid && !item_stall)
        begin
            note = offered_notes.pop_front();
            absorb_value(item, note);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (sorted_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result beat: value %0d end %0b ovf %0b",
                         $realtime, result.sorted_value, result.end_of_run,
                         result.overflowed);
            end
            else
            begin
                want = sorted_due.pop_front();
                if (result.sorted_value !== want.sorted_value ||
                    result.end_of_run !== want.end_of_run ||
                    result.overflowed !== want.overflowed)
                begin
                    fail_count++;
                    $display("%0t: mismatch: expected value %0d end %0b ovf %0b, %s",
                             $realtime, want.sorted_value, want.end_of_run,
                             want.overflowed,
                             $sformatf("got value %0d end %0b ovf %0b",
                                       result.sorted_value, result.end_of_run,
                                       result.overflowed));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // hold the beat until taken, then either carry on the burst or go quiet
    task automatic offer_beat(input item_t b, input bit typed, input result_t want);
        beat_note_t note;
        note.typed = typed;
        note.want = want;
        offered_notes.push_back(note);
        item <= b;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            // now and then a long burst with no gaps at all
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(0, 20);
        end
    endtask

    // go quiet until every owed result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (offered_notes.size() != 0 || sorted_due.size() != 0);
    endtask

    // one whole set, its last beat marked
    task automatic send_set(input int len, input fill_style_t style);
        int      k;
        sval_t   acc;
        sval_t   pool [4];
        item_t   b;
        result_t none;
        none = '0;
        acc = sval_t'($urandom_range(0, 4000)) - 2000;
        for (k = 0; k < 4; k++)
        begin
            if ($urandom_range(0, 1) == 1)
                pool[k] = $urandom;
            else
                pool[k] = sval_t'($urandom_range(0, 6)) - 3;
        end
        for (k = 0; k < len; k++)
        begin
            case (style)
                FILL_SPREAD:
                    b.value = $urandom;
                FILL_FEW:
                    b.value = pool[$urandom_range(0, 3)];
                FILL_EDGES:
                    case ($urandom_range(0, 4))
                        0: b.value = MOST_NEG;
                        1: b.value = MOST_POS;
                        2: b.value = ZERO_V;
                        3: b.value = MINUS_ONE;
                        default: b.value = $urandom;
                    endcase
                FILL_RISING:
                begin
                    acc = acc + sval_t'($urandom_range(0, 3));
                    b.value = acc;
                end
                default:
                begin
                    acc = acc - sval_t'($urandom_range(0, 3));
                    b.value = acc;
                end
            endcase
            b.is_last = (k == len - 1);
            offer_beat(b, 1'b0, none);
        end
    endtask

    initial
    begin : stimulus
        int          k;
        int          len;
        int          pick;
        bit          paused;
        fill_style_t style;
        item_t       b;
        result_t     want;
        paused = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (k = 0; k < PLAN_ROWS; k++)
        begin
            b = {plan_rows[k].value, plan_rows[k].is_last};
            want = {plan_rows[k].want_value, plan_rows[k].want_end, plan_rows[k].want_ovf};
            offer_beat(b, plan_rows[k].typed, want);
        end
        drain_results();

        // exactly full, then overflow with the marked beat itself dropped,
        // then overflow by several beats
        send_set(STORE_DEPTH, FILL_FALLING);
        send_set(STORE_DEPTH + 1, FILL_SPREAD);
        send_set(STORE_DEPTH + 4, FILL_FEW);

        // random sets, mostly short so that many sets complete
        while (beats_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 12);
            else if (pick < 90)
                len = $urandom_range(13, 40);
            else if (pick < 96)
                len = $urandom_range(41, STORE_DEPTH);
            else
                len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
            style = fill_style_t'($urandom_range(FILL_SPREAD, FILL_FALLING));
            send_set(len, style);
            if (!paused && beats_sent >= MID_PAUSE_AT)
            begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && sorted_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern of its own, with one long hold-off once the
    // results are flowing so the engine backs up and stalls its input
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int          span;
        bit          held_long;
        stall_mode_t mode;
        held_long = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_long && results_seen >= HOLD_TRIGGER)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD)
                    @(posedge clk);
                held_long = 1'b1;
            end
            mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_SOLID));
            if (mode == STALL_SOLID)
                span = $urandom_range(1, 8);
            else
                span = $urandom_range(4, 40);
            repeat (span)
            begin
                case (mode)
                    STALL_NONE:  result_stall <= 1'b0;
                    STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: result_stall <= ($urandom_range(0, 2) != 0);
                    default:     result_stall <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    // hang guard
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
sv/qse_pkg.sv
sv/qse_ram.sv
sv/qse_key_cmp.sv
sv/qse_range_stack.sv
sv/quicksort_engine_top.sv
verif/testbench.sv
